@@ design/nrfe_pkg.sv @@
// nrfe_pkg: shared types, constants and lookup functions for the RMC field extractor
// depends on nothing; imported by nrfe_in_reg, nrfe_parse and the top level
`default_nettype none

package nrfe_pkg;

    // sentence buffer limit and derived counter width
    localparam int MAX_SENTENCE = 256;
    localparam int LEN_W        = $clog2(MAX_SENTENCE);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SENTENCE - 1);

    // header and field constants
    localparam logic [2:0] HDR_LEN   = 3'd6;
    localparam logic [3:0] FIELD_SAT = 4'd10;
    localparam logic [3:0] FIELD_LO  = 4'd1;
    localparam logic [3:0] FIELD_HI  = 4'd9;

    // special characters
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    // input register contents handed to the parser
    typedef struct packed {
        logic       vld;
        logic [7:0] rx_byte;
    } t_in_stage;

    // one result word
    typedef struct packed {
        logic [3:0] field_number;
        logic [3:0] char_position;
        logic [7:0] char_value;
        logic       sentence_end;
    } t_result;

    // expected header "$GPRMC" by position
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h24; // '$'
            3'd1:    ch = 8'h47; // 'G'
            3'd2:    ch = 8'h50; // 'P'
            3'd3:    ch = 8'h52; // 'R'
            3'd4:    ch = 8'h4D; // 'M'
            3'd5:    ch = 8'h43; // 'C'
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // per-field character limit, zero outside fields 1..9
    function automatic logic [3:0] field_limit(input logic [3:0] fno);
        logic [3:0] lim;
        case (fno)
            4'd1:    lim = 4'd10;
            4'd2:    lim = 4'd1;
            4'd3:    lim = 4'd9;
            4'd4:    lim = 4'd1;
            4'd5:    lim = 4'd10;
            4'd6:    lim = 4'd1;
            4'd7:    lim = 4'd5;
            4'd8:    lim = 4'd5;
            4'd9:    lim = 4'd6;
            default: lim = 4'd0;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

@@ design/nrfe_if.sv @@
// nrfe_rx_if / nrfe_fld_if: valid/ready channels for received bytes and field results
// depends on nothing
`default_nettype none

interface nrfe_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrfe_fld_if;
    logic       valid;
    logic       ready;
    logic [3:0] field_number;
    logic [3:0] char_position;
    logic [7:0] char_value;
    logic       sentence_end;

    modport source (output valid, output field_number, output char_position,
                    output char_value, output sentence_end, input ready);
    modport sink   (input valid, input field_number, input char_position,
                    input char_value, input sentence_end, output ready);
endinterface

`default_nettype wire

@@ design/nrfe_in_reg.sv @@
// nrfe_in_reg: input register holding one received byte for the parser
// depends on nrfe_pkg and nrfe_rx_if
`default_nettype none

module nrfe_in_reg
    import nrfe_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    nrfe_rx_if.sink        i_rx,
    input  wire logic      i_take,
    output t_in_stage      o_stage
);

    logic       r_vld;
    logic [7:0] r_byte;

    // free when empty or when the parser takes the held word this cycle
    assign i_rx.ready = !r_vld || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_vld <= i_rx.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_stage.vld     = r_vld;
    assign o_stage.rx_byte = r_byte;

endmodule

`default_nettype wire

@@ design/nrfe_parse.sv @@
// nrfe_parse: sentence state, header check, field tracking and result register
// depends on nrfe_pkg and nrfe_fld_if
`default_nettype none

module nrfe_parse
    import nrfe_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_stage i_stage,
    output logic           o_take,
    nrfe_fld_if.source     o_fld
);

    logic [2:0]       r_hdr_pos, n_hdr_pos;
    logic             r_hdr_fail, n_hdr_fail;
    logic [LEN_W-1:0] r_len, n_len;
    logic [3:0]       r_field, n_field;
    logic [3:0]       r_fcnt, n_fcnt;
    logic             r_out_vld;
    t_result          r_out;

    logic    emit;
    t_result res;

    // the held byte moves on when the result register is free or drains now
    assign o_take = i_stage.vld && (!r_out_vld || o_fld.ready);

    // per-byte parse decision
    always_comb begin
        logic [7:0] b;
        logic       stored;
        logic       accepted;
        b          = i_stage.rx_byte;
        n_hdr_pos  = r_hdr_pos;
        n_hdr_fail = r_hdr_fail;
        n_len      = r_len;
        n_field    = r_field;
        n_fcnt     = r_fcnt;
        emit       = 1'b0;
        res        = '0;

        // a dollar sign restarts the sentence
        if (b == CH_DOLLAR) begin
            n_hdr_pos  = '0;
            n_hdr_fail = 1'b0;
            n_len      = '0;
            n_field    = '0;
            n_fcnt     = '0;
        end

        // store into the sentence buffer while room remains
        stored = (n_len < LEN_MAX);
        if (stored) begin
            n_len = n_len + 1'b1;
            if (n_hdr_pos < HDR_LEN) begin
                if (b != hdr_char(n_hdr_pos)) begin
                    n_hdr_fail = 1'b1;
                end
                n_hdr_pos = n_hdr_pos + 1'b1;
            end
        end

        accepted = (n_hdr_pos == HDR_LEN) && !n_hdr_fail;

        if (b == CH_NEWLINE) begin
            // end of sentence
            emit              = accepted;
            res.sentence_end  = 1'b1;
            n_hdr_pos         = '0;
            n_hdr_fail        = 1'b0;
            n_len             = '0;
            n_field           = '0;
            n_fcnt            = '0;
        end else if (stored && accepted) begin
            if (b == CH_COMMA) begin
                if (n_field < FIELD_SAT) begin
                    n_field = n_field + 1'b1;
                end
                n_fcnt = '0;
            end else if (n_field >= FIELD_LO && n_field <= FIELD_HI) begin
                if (n_fcnt < field_limit(n_field)) begin
                    emit              = 1'b1;
                    res.field_number  = n_field;
                    res.char_position = n_fcnt;
                    res.char_value    = b;
                    n_fcnt            = n_fcnt + 1'b1;
                end
            end
        end
    end

    // sentence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos  <= '0;
            r_hdr_fail <= 1'b0;
            r_len      <= '0;
            r_field    <= '0;
            r_fcnt     <= '0;
        end else if (o_take) begin
            r_hdr_pos  <= n_hdr_pos;
            r_hdr_fail <= n_hdr_fail;
            r_len      <= n_len;
            r_field    <= n_field;
            r_fcnt     <= n_fcnt;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_take) begin
            r_out_vld <= emit;
        end else if (o_fld.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_out <= res;
        end
    end

    assign o_fld.valid         = r_out_vld;
    assign o_fld.field_number  = r_out.field_number;
    assign o_fld.char_position = r_out.char_position;
    assign o_fld.char_value    = r_out.char_value;
    assign o_fld.sentence_end  = r_out.sentence_end;

endmodule

`default_nettype wire

@@ design/nmea_rmc_field_extractor.sv @@
// path: a byte accepted into the input register is parsed, and its result word is
//   written to the result register, which drives the output
// throughput: one byte per cycle while the output does not stall, set by the single
//   parse step between the input register and the result register; the result
//   register drains while the next byte is parsed
// reset: synchronous active-low i_rst_n clears sentence state and both valid flags
// nmea_rmc_field_extractor: top level, input register plus parser; uses nrfe_pkg
`default_nettype none

module nmea_rmc_field_extractor
    import nrfe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nrfe_rx_if.sink    i_rx,
    nrfe_fld_if.source o_fld
);

    t_in_stage stage;
    logic      take;

    // input register
    nrfe_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_stage (stage)
    );

    // parser and result register
    nrfe_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .o_take  (take),
        .o_fld   (o_fld)
    );

endmodule

`default_nettype wire

@@ design/nrfe_checker.sv @@
// nrfe_checker: port-level assertions for the RMC field extractor, with bind
// depends on nothing; bound to nmea_rmc_field_extractor
`default_nettype none

module nrfe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] i_field_number,
    input wire logic [3:0] i_char_position,
    input wire logic [7:0] i_char_value,
    input wire logic       i_sentence_end
);

    // a stalled result word holds valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_field_number, i_char_position, i_char_value, i_sentence_end}))
        else $error("result word changed while stalled");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // end word carries zero payload
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sentence_end |->
            i_field_number == 4'd0 && i_char_position == 4'd0 && i_char_value == 8'd0)
        else $error("end word with nonzero payload");

    // character words come from fields one to nine, within the widest limit
    a_char_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_sentence_end |->
            i_field_number >= 4'd1 && i_field_number <= 4'd9 && i_char_position <= 4'd9)
        else $error("character word outside fields one to nine");

    // single-character fields only give position zero
    a_short_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_sentence_end
            && (i_field_number == 4'd2 || i_field_number == 4'd4 || i_field_number == 4'd6)
            |-> i_char_position == 4'd0)
        else $error("single-character field beyond position zero");

endmodule

bind nmea_rmc_field_extractor nrfe_checker u_nrfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_fld.valid),
    .i_out_ready     (o_fld.ready),
    .i_field_number  (o_fld.field_number),
    .i_char_position (o_fld.char_position),
    .i_char_value    (o_fld.char_value),
    .i_sentence_end  (o_fld.sentence_end)
);

`default_nettype wire
